>>> src/ordered_list_insert_delete_core_macros.svh
// assertion macros used by the port level checker
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH

// clocked check, held off while reset is asserted
`define OLID_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// clocked check that also holds through reset
`define OLID_ASSERT_ALW(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

>>> src/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// types and constants of the ordered list block
// ----------------------------------------------------------------------------
package olid_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_NOKEY = 3'd4
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [ADDR_W-1:0]  hit;
        logic [DATA_W-1:0]  value;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_req;

endpackage

>>> src/olid_ram.sv
// ----------------------------------------------------------------------------
// olid_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module olid_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/olid_ctrl.sv
// ----------------------------------------------------------------------------
// olid_ctrl
// sequencer: scans and shifts the list held in ram, keeps the entry count
// ----------------------------------------------------------------------------
module olid_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [5:0]                     i_position,
    input  logic signed [31:0]             i_value,
    output olid_pkg::t_mem_req             o_mem_req,
    input  logic [olid_pkg::DATA_W-1:0]    i_mem_rdata,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output olid_pkg::t_result              o_res
);
    import olid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_END,
        S_INS_PUT,
        S_DEL_SCAN,
        S_DEL_SHIFT,
        S_RD_WAIT,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    t_opcode            r_op, n_op;
    logic [5:0]         r_pos, n_pos;
    logic [DATA_W-1:0]  r_val, n_val;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0]  r_rq, n_rq;
    logic               r_rvld, n_rvld;
    t_result            r_res, n_res;
    t_mem_req           mem_req;
    logic [CNT_W-1:0]   pos_ext;

    assign pos_ext = CNT_W'(i_position);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pos   = r_pos;
        n_val   = r_val;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_rq    = r_rq;
        n_rvld  = 1'b0;
        n_res   = r_res;
        mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op  = t_opcode'(i_opcode);
                    n_pos = i_position;
                    n_val = i_value;
                    n_res = '{status: ST_RANGE, count: r_cnt, hit: '0, value: '0};
                    n_state = S_EMIT;
                    unique case (t_opcode'(i_opcode))
                        OP_INSERT: begin
                            if (pos_ext > r_cnt) begin
                                n_res.status = ST_RANGE;
                            end else if (r_cnt >= CNT_W'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else if (pos_ext == r_cnt) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_ptr   = r_cnt - 1'b1;
                                n_state = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (r_cnt == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_DEL_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (r_cnt == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (pos_ext >= r_cnt) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = i_position[ADDR_W-1:0];
                                n_state       = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_res.status = ST_RANGE;
                        end
                    endcase
                end
            end
            // stream entries up: read ptr, write the previous read one place higher
            S_INS: begin
                if (r_rvld) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_rq + 1'b1;
                    mem_req.wdata = i_mem_rdata;
                end
                mem_req.re    = 1'b1;
                mem_req.raddr = r_ptr[ADDR_W-1:0];
                n_rq   = r_ptr[ADDR_W-1:0];
                n_rvld = 1'b1;
                if (r_ptr == CNT_W'(r_pos)) begin
                    n_state = S_INS_END;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            S_INS_END: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_rq + 1'b1;
                mem_req.wdata = i_mem_rdata;
                n_state       = S_INS_PUT;
            end
            S_INS_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_pos[ADDR_W-1:0];
                mem_req.wdata = r_val;
                n_cnt   = r_cnt + 1'b1;
                n_res   = '{status: ST_OK, count: r_cnt + 1'b1,
                            hit: r_pos[ADDR_W-1:0], value: '0};
                n_state = S_EMIT;
            end
            S_DEL_SCAN: begin
                if (r_rvld && (i_mem_rdata == r_val)) begin
                    n_res   = '{status: ST_OK, count: r_cnt - 1'b1,
                                hit: r_rq, value: i_mem_rdata};
                    n_ptr   = CNT_W'(r_rq) + 1'b1;
                    n_state = S_DEL_SHIFT;
                end else if (r_ptr == r_cnt) begin
                    n_res   = '{status: ST_NOKEY, count: r_cnt, hit: '0, value: '0};
                    n_state = S_EMIT;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_ptr[ADDR_W-1:0];
                    n_rq   = r_ptr[ADDR_W-1:0];
                    n_rvld = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end
            end
            // stream entries down over the removed slot
            S_DEL_SHIFT: begin
                if (r_rvld) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_rq - 1'b1;
                    mem_req.wdata = i_mem_rdata;
                end
                if (r_ptr == r_cnt) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_ptr[ADDR_W-1:0];
                    n_rq   = r_ptr[ADDR_W-1:0];
                    n_rvld = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end
            end
            S_RD_WAIT: begin
                n_res   = '{status: ST_OK, count: r_cnt,
                            hit: r_pos[ADDR_W-1:0], value: i_mem_rdata};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rvld  <= n_rvld;
        end
        r_op  <= n_op;
        r_pos <= n_pos;
        r_val <= n_val;
        r_ptr <= n_ptr;
        r_rq  <= n_rq;
        r_res <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;
    assign o_mem_req   = mem_req;

endmodule

>>> src/ordered_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// bounded list of signed 32-bit values with insert, delete by key and read
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready carries opcode, position and value; one
//   transaction per item. output channel o_valid/i_ready carries status,
//   new count, hit index and read value; exactly one result per item.
//   entries live in a 32 x 32 ram with a registered read. insert at position
//   p below the entry count n shifts the entries from p upward through the
//   ram read port, then writes the new value; an append only writes it.
//   delete compares entries up to the match, then moves each later entry
//   down one place; when the key is missing all n entries are compared.
//   read fetches the entry at the position; rejected items go straight to
//   the result. the ram's single read port allows one entry moved or
//   compared per cycle. a result sits in an output register, so the next
//   item is taken while the receiver stalls; the sequencer only waits when
//   a second result is ready before the first has left.
//   reset clears the entry count; ram contents need no clearing since only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [5:0]         o_new_count,
    output logic [4:0]         o_hit_index,
    output logic signed [31:0] o_read_value
);
    import olid_pkg::*;

    t_mem_req           mem_req;
    logic [DATA_W-1:0]  mem_rdata;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               r_ovld;
    t_result            r_out;

    olid_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    olid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register, free when empty or being taken this cycle
    assign res_ready = !r_ovld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_ready) begin
            r_ovld <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_ovld;
    assign o_status     = r_out.status;
    assign o_new_count  = 6'(r_out.count);
    assign o_hit_index  = 5'(r_out.hit);
    assign o_read_value = r_out.value;

endmodule

>>> src/olid_checker.sv
// ----------------------------------------------------------------------------
// olid_checker
// port level checks on both channels of the ordered list block
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_core_macros.svh"

module olid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [2:0]         o_status,
    input logic [5:0]         o_new_count,
    input logic [4:0]         o_hit_index,
    input logic signed [31:0] o_read_value
);
    import olid_pkg::*;

    `OLID_ASSERT_RST(a_err_no_index, i_clk, i_rst_n, (o_valid && (o_status != ST_OK)) |-> ((o_hit_index == '0) && (o_read_value == '0)))
    `OLID_ASSERT_RST(a_count_bound, i_clk, i_rst_n, o_valid |-> (o_new_count <= 6'(CAPACITY)))
    `OLID_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_new_count) && $stable(o_read_value)))
    `OLID_ASSERT_RST(a_accept_busy, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)
    `OLID_ASSERT_ALW(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind ordered_list_insert_delete_core olid_checker u_olid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_new_count  (o_new_count),
    .o_hit_index  (o_hit_index),
    .o_read_value (o_read_value)
);

>>> sim/olid_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_list_checker
// watches both channels of the ordered list block, keeps its own copy of the
// list, works out the answer to every accepted transaction and compares each
// returned result with the oldest answer still owed
// ----------------------------------------------------------------------------
module olid_list_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_position,
    input  logic [31:0] i_value,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_new_count,
    input  logic [4:0]  i_hit_index,
    input  logic [31:0] i_read_value,
    output int          o_errors,
    output int          o_pending,
    output int          o_held,
    output int          o_results,
    output int          o_full_seen,
    output int          o_nokey_seen
);
    import olid_pkg::*;

    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                held       = 0;
    int                mismatches = 0;
    int                n_results  = 0;
    int                n_full     = 0;
    int                n_nokey    = 0;
    t_result           answer_q [$];

    // applies one operation to the local list and returns the answer it owes
    function automatic t_result list_apply(input t_opcode op, input int pos,
                                           input logic [31:0] key);
        t_result r;
        int      hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        case (op)
            OP_INSERT: begin
                if (pos > held) begin
                    r.status = ST_RANGE;
                end else if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = held; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = key;
                    held++;
                    r.hit = ADDR_W'(pos);
                end
            end
            OP_DELETE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // first match wins
                    for (int i = 0; i < held && hit < 0; i++)
                        if (list_mem[i] == key) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOKEY;
                    end else begin
                        r.hit   = ADDR_W'(hit);
                        r.value = list_mem[hit];
                        for (int i = hit; i + 1 < held; i++)
                            list_mem[i] = list_mem[i+1];
                        held--;
                    end
                end
            end
            OP_READ: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= held) begin
                    r.status = ST_RANGE;
                end else begin
                    r.hit   = ADDR_W'(pos);
                    r.value = list_mem[pos];
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.count = CNT_W'(held);
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $realtime, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                answer_q.push_back(list_apply(t_opcode'(i_opcode), i_position, i_value));
            if (i_rsp_valid && i_rsp_ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: result with no transaction outstanding, status %0d",
                                 $realtime, i_status);
                end else begin
                    want = answer_q.pop_front();
                    n_results++;
                    if (i_status !== want.status)
                        flag_field("status", 32'(want.status), 32'(i_status));
                    if (i_new_count !== want.count)
                        flag_field("new_count", 32'(want.count), 32'(i_new_count));
                    if (i_hit_index !== want.hit)
                        flag_field("hit_index", 32'(want.hit), 32'(i_hit_index));
                    if (i_read_value !== want.value)
                        flag_field("read_value", want.value, i_read_value);
                    if (want.status == ST_FULL)
                        n_full++;
                    if (want.status == ST_NOKEY)
                        n_nokey++;
                end
            end
        end
        o_errors     = mismatches;
        o_pending    = answer_q.size();
        o_held       = held;
        o_results    = n_results;
        o_full_seen  = n_full;
        o_nokey_seen = n_nokey;
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives insert, delete, read and unused opcodes into the ordered list core
// with random gaps and back-pressure; the list checker beside the core
// predicts and compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
    import olid_pkg::*;

    localparam int NUM_RANDOM = 1740;
    localparam int HOLD_LEN   = 200;
    localparam int POOL_SIZE  = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_opcode;
    logic [5:0]         i_position;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [2:0]         o_status;
    logic [5:0]         o_new_count;
    logic [4:0]         o_hit_index;
    logic signed [31:0] o_read_value;

    logic no_idle  = 1'b0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;

    int errors, pending, held, results, full_seen, nokey_seen;
    int n_sent = 0;

    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] fresh_vals [8];

    ordered_list_insert_delete_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_new_count  (o_new_count),
        .o_hit_index  (o_hit_index),
        .o_read_value (o_read_value)
    );

    olid_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_status     (o_status),
        .i_new_count  (o_new_count),
        .i_hit_index  (o_hit_index),
        .i_read_value (o_read_value),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_held       (held),
        .o_results    (results),
        .o_full_seen  (full_seen),
        .o_nokey_seen (nokey_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
            end else if (no_idle) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_op(input t_opcode op, input logic [5:0] pos,
                           input logic [31:0] val);
        if (!no_idle)
            while ($urandom_range(0, 99) < 11) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    initial begin
        int          roll;
        int          fresh_wr;
        bit          grow;
        t_opcode     op;
        logic [5:0]  pos;
        logic [31:0] val;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_opcode   = OP_INSERT;
        i_position = '0;
        i_value    = '0;
        fresh_wr   = 0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        for (int k = 4; k < POOL_SIZE; k++)
            key_pool[k] = $urandom;
        for (int k = 0; k < 8; k++)
            fresh_vals[k] = $urandom;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list, bad positions, unused opcode
        send_op(OP_READ,   6'd0,  32'd0);
        send_op(OP_DELETE, 6'd0,  32'd5);
        send_op(OP_INSERT, 6'd1,  32'd9);
        send_op(OP_INSERT, 6'd63, 32'd9);
        send_op(OP_NONE,   6'd63, 32'hFFFF_FFFF);
        // append, front and middle inserts with extreme values
        send_op(OP_INSERT, 6'd0,  32'h7FFF_FFFF);
        send_op(OP_INSERT, 6'd1,  32'h8000_0000);
        send_op(OP_INSERT, 6'd0,  32'hFFFF_FFFF);
        send_op(OP_INSERT, 6'd1,  32'h0000_0000);
        send_op(OP_INSERT, 6'd5,  32'd1);
        send_op(OP_READ,   6'd0,  32'd0);
        send_op(OP_READ,   6'd3,  32'd0);
        send_op(OP_READ,   6'd4,  32'd0);
        send_op(OP_READ,   6'd63, 32'd0);
        // missing key, last entry, first entry, duplicate keys
        send_op(OP_DELETE, 6'd0,  32'd12345);
        send_op(OP_DELETE, 6'd0,  32'h8000_0000);
        send_op(OP_DELETE, 6'd0,  32'hFFFF_FFFF);
        send_op(OP_INSERT, 6'd0,  32'h7FFF_FFFF);
        send_op(OP_DELETE, 6'd63, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 6'd2,  32'h5555_AAAA);
        send_op(OP_READ,   6'd2,  32'd0);

        // fill to capacity and beyond while results are held back
        hold_req <= 1'b1;
        for (int k = 0; k < 36; k++)
            send_op(OP_INSERT, 6'd0, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // alternate growing and shrinking phases so the list swings end to end
        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle <= (n >= 700 && n < 950);
            grow = ((n / 120) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 55 : 15))
                op = OP_INSERT;
            else if (roll < 70)
                op = OP_DELETE;
            else if (roll < 96)
                op = OP_READ;
            else
                op = OP_NONE;

            if ($urandom_range(0, 99) < 15)
                pos = 6'($urandom_range(0, 63));
            else if (op == OP_INSERT)
                pos = 6'($urandom_range(0, held));
            else
                pos = 6'($urandom_range(0, (held > 0) ? held - 1 : 0));

            roll = $urandom_range(0, 99);
            if (op == OP_INSERT) begin
                if (roll < 75) begin
                    val = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else begin
                    val = $urandom;
                    fresh_vals[fresh_wr] = val;
                    fresh_wr = (fresh_wr + 1) % 8;
                end
            end else if (roll < 70) begin
                val = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (roll < 90) begin
                val = fresh_vals[$urandom_range(0, 7)];
            end else begin
                val = $urandom;
            end
            send_op(op, pos, val);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);

        $display("%0d list transactions driven, %0d results checked", n_sent, results);
        $display("rejections seen: %0d on a full list, %0d deletes of a missing key",
                 full_seen, nokey_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
